@@ rtl/bsic_pkg.sv @@
// Package for the counted bubble sort: sizes, sequencer states and store request type.
package bsic_pkg;

  localparam int unsigned MAX_ITEMS = 32;
  localparam int unsigned ITEM_W    = 32;
  localparam int unsigned IDX_W     = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int unsigned CMP_W     = 11;

  typedef enum logic [2:0] {
    S_LOAD,
    S_PASS,
    S_FIRST,
    S_RUN,
    S_TAIL,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_WAIT
  } state_e;

  typedef struct packed {
    logic                     we;
    logic [IDX_W-1:0]         waddr;
    logic signed [ITEM_W-1:0] wdata;
    logic [IDX_W-1:0]         raddr;
  } mem_req_t;

endpackage

@@ rtl/bsic_store.sv @@
// Element store: one write port, one read port with registered read data.
module bsic_store (
  input  logic                               clk_i,
  input  bsic_pkg::mem_req_t                 req_i,
  output logic signed [bsic_pkg::ITEM_W-1:0] rdata_o
);

  logic signed [bsic_pkg::ITEM_W-1:0] mem [bsic_pkg::MAX_ITEMS];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end

endmodule

@@ rtl/bsic_cmp.sv @@
// Compare unit: flags a pair that is out of order for the selected direction.
module bsic_cmp (
  input  logic signed [bsic_pkg::ITEM_W-1:0] a_i,
  input  logic signed [bsic_pkg::ITEM_W-1:0] b_i,
  input  logic                               descending_i,
  output logic                               swap_o
);

  always_comb begin
    if (descending_i) begin
      swap_o = a_i < b_i;
    end else begin
      swap_o = a_i > b_i;
    end
  end

endmodule

@@ rtl/bsic_ctrl.sv @@
// Sequencer: loads words, runs early-exit bubble passes with a carry register, emits results.
module bsic_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [bsic_pkg::ITEM_W-1:0] value_i,
  input  logic                               last_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [bsic_pkg::ITEM_W-1:0] sorted_value_o,
  output logic                               last_out_o,
  output logic [bsic_pkg::CMP_W-1:0]         compare_count_o,
  output logic                               overflowed_o,
  output bsic_pkg::mem_req_t                 req_o,
  input  logic signed [bsic_pkg::ITEM_W-1:0] rdata_i,
  input  logic                               swap_i,
  output logic signed [bsic_pkg::ITEM_W-1:0] carry_o
);

  localparam logic [bsic_pkg::CNT_W-1:0] MaxCnt = bsic_pkg::CNT_W'(bsic_pkg::MAX_ITEMS);

  bsic_pkg::state_e state_q, state_d;
  logic [bsic_pkg::CNT_W-1:0]         cnt_q, cnt_d;
  logic [bsic_pkg::CNT_W-1:0]         cnt_m1;
  logic [bsic_pkg::IDX_W-1:0]         lim_q, lim_d;
  logic [bsic_pkg::IDX_W-1:0]         idx_q, idx_d;
  logic [bsic_pkg::CMP_W-1:0]         cmp_q, cmp_d;
  logic                               swp_q, swp_d;
  logic                               drop_q, drop_d;
  logic                               ov_q, ov_d;
  logic signed [bsic_pkg::ITEM_W-1:0] carry_q, carry_d;
  logic                               load_out;

  assign carry_o     = carry_q;
  assign out_valid_o = ov_q;
  assign in_stall_o  = (state_q != bsic_pkg::S_LOAD);
  assign cnt_m1      = cnt_d - bsic_pkg::CNT_W'(1);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    lim_d       = lim_q;
    idx_d       = idx_q;
    cmp_d       = cmp_q;
    swp_d       = swp_q;
    drop_d      = drop_q;
    ov_d        = ov_q;
    carry_d     = carry_q;
    load_out    = 1'b0;
    req_o.we    = 1'b0;
    req_o.waddr = idx_q;
    req_o.wdata = carry_q;
    req_o.raddr = idx_q;
    case (state_q)
      bsic_pkg::S_LOAD: begin
        if (in_valid_i) begin
          if (cnt_q < MaxCnt) begin
            req_o.we    = 1'b1;
            req_o.waddr = cnt_q[bsic_pkg::IDX_W-1:0];
            req_o.wdata = value_i;
            cnt_d       = cnt_q + bsic_pkg::CNT_W'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (last_item_i) begin
            lim_d   = cnt_m1[bsic_pkg::IDX_W-1:0];
            cmp_d   = '0;
            state_d = bsic_pkg::S_PASS;
          end
        end
      end
      bsic_pkg::S_PASS: begin
        swp_d = 1'b0;
        if (lim_q == '0) begin
          idx_d   = '0;
          state_d = bsic_pkg::S_EMIT_RD;
        end else begin
          req_o.raddr = '0;
          state_d     = bsic_pkg::S_FIRST;
        end
      end
      bsic_pkg::S_FIRST: begin
        carry_d     = rdata_i;
        idx_d       = '0;
        req_o.raddr = bsic_pkg::IDX_W'(1);
        state_d     = bsic_pkg::S_RUN;
      end
      bsic_pkg::S_RUN: begin
        cmp_d       = cmp_q + bsic_pkg::CMP_W'(1);
        req_o.we    = 1'b1;
        req_o.waddr = idx_q;
        req_o.raddr = idx_q + bsic_pkg::IDX_W'(2);
        if (swap_i) begin
          req_o.wdata = rdata_i;
          swp_d       = 1'b1;
        end else begin
          req_o.wdata = carry_q;
          carry_d     = rdata_i;
        end
        if (idx_q + bsic_pkg::IDX_W'(1) == lim_q) begin
          state_d = bsic_pkg::S_TAIL;
        end else begin
          idx_d = idx_q + bsic_pkg::IDX_W'(1);
        end
      end
      bsic_pkg::S_TAIL: begin
        req_o.we    = 1'b1;
        req_o.waddr = lim_q;
        req_o.wdata = carry_q;
        lim_d       = lim_q - bsic_pkg::IDX_W'(1);
        if (swp_q) begin
          state_d = bsic_pkg::S_PASS;
        end else begin
          idx_d   = '0;
          state_d = bsic_pkg::S_EMIT_RD;
        end
      end
      bsic_pkg::S_EMIT_RD: begin
        req_o.raddr = idx_q;
        state_d     = bsic_pkg::S_EMIT_LD;
      end
      bsic_pkg::S_EMIT_LD: begin
        load_out = 1'b1;
        ov_d     = 1'b1;
        state_d  = bsic_pkg::S_EMIT_WAIT;
      end
      bsic_pkg::S_EMIT_WAIT: begin
        if (!out_stall_i) begin
          ov_d = 1'b0;
          if (last_out_o) begin
            cnt_d   = '0;
            cmp_d   = '0;
            drop_d  = 1'b0;
            lim_d   = '0;
            swp_d   = 1'b0;
            state_d = bsic_pkg::S_LOAD;
          end else begin
            idx_d   = idx_q + bsic_pkg::IDX_W'(1);
            state_d = bsic_pkg::S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = bsic_pkg::S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsic_pkg::S_LOAD;
      cnt_q   <= '0;
      lim_q   <= '0;
      idx_q   <= '0;
      cmp_q   <= '0;
      swp_q   <= 1'b0;
      drop_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      lim_q   <= lim_d;
      idx_q   <= idx_d;
      cmp_q   <= cmp_d;
      swp_q   <= swp_d;
      drop_q  <= drop_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    if (load_out) begin
      sorted_value_o  <= rdata_i;
      last_out_o      <= ({1'b0, idx_q} + bsic_pkg::CNT_W'(1)) == cnt_q;
      compare_count_o <= cmp_q;
      overflowed_o    <= drop_q;
    end
  end

endmodule

@@ rtl/bubble_sort_int_counted_core.sv @@
// Top level of the counted early-exit bubble sort of signed 32-bit words.
// Load: one word per cycle; input stall stays high from the last word until all results leave.
// Sort: early-exit passes, at most N - 1 passes for N words; the sort ends when a pass makes
// no swap or when the compare range has run down to zero.
// Emit: each result word is read from the store, loaded into the output registers and held while the output stalls.
// Reset clears the sequencer, counters, flags and the direction register; the store is not cleared.
module bubble_sort_int_counted_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic                               cfg_descending_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [bsic_pkg::ITEM_W-1:0] value_i,
  input  logic                               last_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [bsic_pkg::ITEM_W-1:0] sorted_value_o,
  output logic                               last_out_o,
  output logic [bsic_pkg::CMP_W-1:0]         compare_count_o,
  output logic                               overflowed_o
);

  logic                               desc_q;
  bsic_pkg::mem_req_t                 req;
  logic signed [bsic_pkg::ITEM_W-1:0] rdata;
  logic signed [bsic_pkg::ITEM_W-1:0] carry;
  logic                               swap;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      desc_q <= cfg_descending_i;
    end
  end

  bsic_store u_store (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  bsic_cmp u_cmp (
    .a_i          (carry),
    .b_i          (rdata),
    .descending_i (desc_q),
    .swap_o       (swap)
  );

  bsic_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .value_i         (value_i),
    .last_item_i     (last_item_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sorted_value_o  (sorted_value_o),
    .last_out_o      (last_out_o),
    .compare_count_o (compare_count_o),
    .overflowed_o    (overflowed_o),
    .req_o           (req),
    .rdata_i         (rdata),
    .swap_i          (swap),
    .carry_o         (carry)
  );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the counted early-exit bubble sort core.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned ITEM_W    = bsic_pkg::ITEM_W;
  localparam int unsigned CMP_W     = bsic_pkg::CMP_W;
  localparam int unsigned MAX_ITEMS = bsic_pkg::MAX_ITEMS;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RAND_WORDS  = 430;
  localparam logic signed [ITEM_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [ITEM_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam bit ASCEND  = 1'b0;
  localparam bit DESCEND = 1'b1;

  typedef struct packed {
    logic signed [ITEM_W-1:0] val;
    logic                     last;
    logic [CMP_W-1:0]         cmp;
    logic                     ovf;
  } sorted_word_t;

  typedef struct packed {
    logic signed [ITEM_W-1:0] val;
    logic                     last;
    logic                     wr_dir;
    logic                     dir;
    logic                     typed;
    logic signed [ITEM_W-1:0] exp_val;
    logic [CMP_W-1:0]         exp_cmp;
  } dir_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic                     cfg_descending_i = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic signed [ITEM_W-1:0] value_i = '0;
  logic                     last_item_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [ITEM_W-1:0] sorted_value_o;
  logic                     last_out_o;
  logic [CMP_W-1:0]         compare_count_o;
  logic                     overflowed_o;

  // predictor copy of the array being loaded
  logic signed [ITEM_W-1:0] arr [MAX_ITEMS];
  int                       arr_len = 0;
  bit                       arr_dropped = 1'b0;
  bit                       dir_desc = 1'b0;

  sorted_word_t sorted_words_q [$];
  dir_row_t     dir_tab [$];
  int           errors = 0;
  int           cycle_cnt = 0;
  int           quiet_left [2];

  bubble_sort_int_counted_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_descending_i(cfg_descending_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .value_i         (value_i),
    .last_item_i     (last_item_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sorted_value_o  (sorted_value_o),
    .last_out_o      (last_out_o),
    .compare_count_o (compare_count_o),
    .overflowed_o    (overflowed_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("bubble_sort_int_counted_core regression: fail");
      $finish;
    end
  end

  function automatic int draw_gap(input int side);
    if (quiet_left[side] > 0) begin
      quiet_left[side]--;
      return 0;
    end
    if ($urandom_range(9) == 0) begin
      quiet_left[side] = $urandom_range(30, 8);
      return 0;
    end
    return $urandom_range(12);
  endfunction

  function automatic dir_row_t dir_row(input logic signed [ITEM_W-1:0] v, input bit lst,
                                       input bit wr, input bit d, input bit typed,
                                       input logic signed [ITEM_W-1:0] ev,
                                       input logic [CMP_W-1:0] ec);
    dir_row_t r;
    r.val = v; r.last = lst; r.wr_dir = wr; r.dir = d;
    r.typed = typed; r.exp_val = ev; r.exp_cmp = ec;
    return r;
  endfunction

  function automatic logic signed [ITEM_W-1:0] rand_value();
    case ($urandom_range(7))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return int'($urandom_range(6)) - 3;
      3: return $urandom_range(1) ? 32'sd0 : -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d", field, got, want);
    errors++;
  endtask

  // store one word; on the last word sort with early exit and, if queue_it is set, queue the results
  task automatic take_word(input logic signed [ITEM_W-1:0] v, input bit lst,
                           input bit queue_it);
    sorted_word_t       w;
    logic signed [ITEM_W-1:0] t;
    int                 lim;
    int                 cmps;
    bit                 swp;
    bit                 ooo;
    if (arr_len < MAX_ITEMS) begin
      arr[arr_len] = v;
      arr_len++;
    end else begin
      arr_dropped = 1'b1;
    end
    if (lst) begin
      cmps = 0;
      lim = arr_len - 1;
      do begin
        swp = 1'b0;
        for (int i = 0; i < lim; i++) begin
          cmps++;
          ooo = dir_desc ? (arr[i] < arr[i+1]) : (arr[i] > arr[i+1]);
          if (ooo) begin
            t = arr[i];
            arr[i] = arr[i+1];
            arr[i+1] = t;
            swp = 1'b1;
          end
        end
        if (lim > 0) lim--;
      end while (swp);
      for (int k = 0; k < arr_len; k++) begin
        w.val = arr[k];
        w.last = (k == arr_len - 1);
        w.cmp = cmps[CMP_W-1:0];
        w.ovf = arr_dropped;
        if (queue_it) sorted_words_q.push_back(w);
      end
      arr_len = 0;
      arr_dropped = 1'b0;
    end
  endtask

  task automatic send_word(input logic signed [ITEM_W-1:0] v, input bit lst,
                           input bit queue_it);
    int gap;
    gap = draw_gap(0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i <= v;
    last_item_i <= lst;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    take_word(v, lst, queue_it);
  endtask

  // only between arrays, once all results are out
  task automatic set_direction(input bit d);
    in_valid_i <= 1'b0;
    while (sorted_words_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_descending_i <= d;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    dir_desc = d;
  endtask

  initial begin : drain
    int gap;
    sorted_word_t w;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = draw_gap(1);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(negedge clk_i); while (!out_valid_o);
      if (sorted_words_q.size() == 0) begin
        report_mismatch("unexpected word", longint'(sorted_value_o), longint'(0));
      end else begin
        w = sorted_words_q.pop_front();
        if (sorted_value_o !== w.val)
          report_mismatch("sorted_value", longint'(sorted_value_o), longint'(w.val));
        if (last_out_o !== w.last)
          report_mismatch("last_out", longint'(last_out_o), longint'(w.last));
        if (compare_count_o !== w.cmp)
          report_mismatch("compare_count", longint'(compare_count_o), longint'(w.cmp));
        if (overflowed_o !== w.ovf)
          report_mismatch("overflowed", longint'(overflowed_o), longint'(w.ovf));
      end
      @(posedge clk_i);
    end
  end

  initial begin : stimulus
    sorted_word_t w;
    int sent;
    int len;
    int mode;
    int base;
    bit first;
    logic signed [ITEM_W-1:0] v;
    quiet_left[0] = 0;
    quiet_left[1] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single words: result is the word itself, no compares; then a three-word array in each direction
    dir_tab.push_back(dir_row(VAL_MIN, 1'b1, 1'b1, ASCEND, 1'b1, VAL_MIN, '0));
    dir_tab.push_back(dir_row(VAL_MAX, 1'b1, 1'b0, ASCEND, 1'b1, VAL_MAX, '0));
    dir_tab.push_back(dir_row(32'sd0, 1'b1, 1'b0, ASCEND, 1'b1, 32'sd0, '0));
    dir_tab.push_back(dir_row(-32'sd1, 1'b1, 1'b1, DESCEND, 1'b1, -32'sd1, '0));
    dir_tab.push_back(dir_row(VAL_MIN, 1'b0, 1'b0, DESCEND, 1'b0, 32'sd0, '0));
    dir_tab.push_back(dir_row(VAL_MAX, 1'b0, 1'b0, DESCEND, 1'b0, 32'sd0, '0));
    dir_tab.push_back(dir_row(32'sd0, 1'b1, 1'b0, DESCEND, 1'b0, 32'sd0, '0));
    dir_tab.push_back(dir_row(VAL_MAX, 1'b0, 1'b1, ASCEND, 1'b0, 32'sd0, '0));
    dir_tab.push_back(dir_row(32'sd0, 1'b0, 1'b0, ASCEND, 1'b0, 32'sd0, '0));
    dir_tab.push_back(dir_row(VAL_MIN, 1'b1, 1'b0, ASCEND, 1'b0, 32'sd0, '0));
    // equal values keep their order
    dir_tab.push_back(dir_row(32'sd5, 1'b0, 1'b0, ASCEND, 1'b0, 32'sd0, '0));
    dir_tab.push_back(dir_row(32'sd5, 1'b0, 1'b0, ASCEND, 1'b0, 32'sd0, '0));
    dir_tab.push_back(dir_row(-32'sd3, 1'b0, 1'b0, ASCEND, 1'b0, 32'sd0, '0));
    dir_tab.push_back(dir_row(32'sd5, 1'b1, 1'b0, ASCEND, 1'b0, 32'sd0, '0));
    // already sorted: one pass
    dir_tab.push_back(dir_row(32'sd1, 1'b0, 1'b0, ASCEND, 1'b0, 32'sd0, '0));
    dir_tab.push_back(dir_row(32'sd2, 1'b0, 1'b0, ASCEND, 1'b0, 32'sd0, '0));
    dir_tab.push_back(dir_row(32'sd3, 1'b0, 1'b0, ASCEND, 1'b0, 32'sd0, '0));
    dir_tab.push_back(dir_row(32'sd4, 1'b1, 1'b0, ASCEND, 1'b0, 32'sd0, '0));
    // reversed: every pass swaps; then a two-word array already in order
    dir_tab.push_back(dir_row(32'sd1, 1'b0, 1'b1, DESCEND, 1'b0, 32'sd0, '0));
    dir_tab.push_back(dir_row(32'sd2, 1'b0, 1'b0, DESCEND, 1'b0, 32'sd0, '0));
    dir_tab.push_back(dir_row(32'sd3, 1'b0, 1'b0, DESCEND, 1'b0, 32'sd0, '0));
    dir_tab.push_back(dir_row(32'sd4, 1'b1, 1'b0, DESCEND, 1'b0, 32'sd0, '0));
    dir_tab.push_back(dir_row(32'sh5555_5555, 1'b0, 1'b0, DESCEND, 1'b0, 32'sd0, '0));
    dir_tab.push_back(dir_row(32'shaaaa_aaaa, 1'b1, 1'b0, DESCEND, 1'b0, 32'sd0, '0));

    foreach (dir_tab[r]) begin
      if (dir_tab[r].wr_dir) set_direction(dir_tab[r].dir);
      send_word(dir_tab[r].val, dir_tab[r].last, !dir_tab[r].typed);
      if (dir_tab[r].typed) begin
        w.val = dir_tab[r].exp_val;
        w.last = 1'b1;
        w.cmp = dir_tab[r].exp_cmp;
        w.ovf = 1'b0;
        sorted_words_q.push_back(w);
      end
    end

    sent = 0;
    first = 1'b1;
    while (sent < RAND_WORDS) begin
      if (first) begin
        len = 36;
        set_direction(ASCEND);
      end else begin
        case ($urandom_range(99)) inside
          [0:54]:  len = $urandom_range(6, 1);
          [55:79]: len = $urandom_range(20, 7);
          [80:91]: len = $urandom_range(32, 21);
          default: len = $urandom_range(40, 33);
        endcase
        if ($urandom_range(3) == 0) set_direction(1'($urandom_range(1)));
      end
      mode = $urandom_range(5);
      base = int'($urandom_range(200)) - 100;
      for (int i = 0; i < len; i++) begin
        if (first) v = i[0] ? VAL_MAX : VAL_MIN;
        else if (mode == 0) v = base + i;
        else if (mode == 1) v = base - i;
        else v = rand_value();
        send_word(v, i == len - 1, 1'b1);
      end
      sent += len;
      first = 1'b0;
    end

    in_valid_i <= 1'b0;
    while (sorted_words_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("bubble_sort_int_counted_core regression: pass");
    end else begin
      $display("bubble_sort_int_counted_core regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/bsic_pkg.sv
rtl/bsic_store.sv
rtl/bsic_cmp.sv
rtl/bsic_ctrl.sv
rtl/bubble_sort_int_counted_core.sv
tb/tb.sv
